@@ sv/gifm_pkg.sv @@
`timescale 1ns / 1ps
// gifm_pkg: shared constants, register codes and queue types for the
// gradient importance freeze mask block; depends on nothing

package gifm_pkg;

  localparam int unsigned MAX_PARAMS_DEF = 1024;
  localparam int unsigned QUEUE_DEPTH    = 2;

  // widest element index over the allowed parameter range
  localparam int unsigned IDX_W   = 16;
  localparam int unsigned GRAD_W  = 24;
  localparam int unsigned IMP_W   = 32;
  localparam int unsigned DECAY_W = 17;
  localparam int unsigned COUNT_W = 11;
  localparam int unsigned TOTAL_W = 48;
  localparam int unsigned PADDR_W = 4;

  localparam logic [DECAY_W-1:0] ONE_Q16 = 17'h10000;

  localparam logic [IMP_W-1:0]   THRESHOLD_RST = 32'd1311;
  localparam logic [DECAY_W-1:0] DECAY_RST     = 17'd58982;
  localparam logic [COUNT_W-1:0] PCOUNT_RST    = 11'd1024;

  localparam logic [1:0] REG_THRESHOLD = 2'd0;
  localparam logic [1:0] REG_DECAY     = 2'd1;
  localparam logic [1:0] REG_PCOUNT    = 2'd2;

  localparam logic OP_GRADIENT = 1'b0;
  localparam logic OP_DECAY    = 1'b1;

  // one classified item on its way from front to back
  typedef struct packed {
    logic                     op;
    logic signed [GRAD_W-1:0] grad;
    logic [IDX_W-1:0]         idx;
    logic                     last;
  } work_t;

  typedef struct packed {
    logic signed [GRAD_W-1:0] masked_gradient;
    logic                     frozen;
    logic                     first_freeze;
    logic                     last;
    logic [COUNT_W-1:0]       freeze_count;
    logic [COUNT_W-1:0]       newly_frozen_count;
    logic [COUNT_W-1:0]       masked_count;
    logic [TOTAL_W-1:0]       masked_running_total;
  } result_t;

endpackage

@@ sv/gifm_if.sv @@
`timescale 1ns / 1ps
// gifm_in_if and gifm_out_if: valid/ready channels of the freeze mask block
// standalone, no package needed

interface gifm_in_if;
  logic               valid;
  logic               ready;
  logic               opcode;
  logic signed [23:0] gradient;
  logic               gradient_invalid;

  modport source (output valid, output opcode, output gradient, output gradient_invalid,
                  input ready);
  modport sink (input valid, input opcode, input gradient, input gradient_invalid,
                output ready);
endinterface

interface gifm_out_if;
  logic               valid;
  logic               ready;
  logic signed [23:0] masked_gradient;
  logic               frozen;
  logic               first_freeze;
  logic               last;
  logic [10:0]        freeze_count;
  logic [10:0]        newly_frozen_count;
  logic [10:0]        masked_count;
  logic [47:0]        masked_running_total;

  modport source (output valid, output masked_gradient, output frozen, output first_freeze,
                  output last, output freeze_count, output newly_frozen_count,
                  output masked_count, output masked_running_total, input ready);
  modport sink (input valid, input masked_gradient, input frozen, input first_freeze,
                input last, input freeze_count, input newly_frozen_count,
                input masked_count, input masked_running_total, output ready);
endinterface

@@ sv/gifm_ram.sv @@
`timescale 1ns / 1ps
// gifm_ram: generic single write port, single read port ram, registered read
// standalone, no package needed

module gifm_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 1024,
  parameter int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

@@ sv/gifm_queue.sv @@
`timescale 1ns / 1ps
// gifm_queue: short fifo of classified items between front and back
// depends on gifm_pkg

module gifm_queue #(
  parameter int unsigned DEPTH = gifm_pkg::QUEUE_DEPTH
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_valid_i,
  input  gifm_pkg::work_t push_data_i,
  output logic            push_ready_o,
  output logic            pop_valid_o,
  output gifm_pkg::work_t pop_data_o,
  input  logic            pop_ready_i
);
  import gifm_pkg::*;

  localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  work_t         slot_q [DEPTH];
  logic [PW-1:0] wr_q, wr_d, rd_q, rd_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic          push, pop;

  assign push_ready_o = (cnt_q != CW'(DEPTH));
  assign pop_valid_o  = (cnt_q != '0);
  assign pop_data_o   = slot_q[rd_q];
  assign push         = push_valid_i & push_ready_o;
  assign pop          = pop_ready_i & pop_valid_o;

  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (push) begin
      wr_d = (wr_q == PW'(DEPTH - 1)) ? '0 : PW'(wr_q + 1'b1);
    end
    if (pop) begin
      rd_d = (rd_q == PW'(DEPTH - 1)) ? '0 : PW'(rd_q + 1'b1);
    end
    if (push && !pop) begin
      cnt_d = CW'(cnt_q + 1'b1);
    end else if (pop && !push) begin
      cnt_d = CW'(cnt_q - 1'b1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      slot_q[wr_q] <= push_data_i;
    end
  end

endmodule

@@ sv/gifm_front.sv @@
`timescale 1ns / 1ps
// gifm_front: accepts input transfers, tracks the element position and
// classifies each item (index, last flag); depends on gifm_pkg, gifm_if

module gifm_front #(
  parameter int unsigned MAX_PARAMS = gifm_pkg::MAX_PARAMS_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  gifm_in_if.sink                       in_i,
  input  logic [gifm_pkg::COUNT_W-1:0]  param_count_i,
  input  logic                          clearing_i,
  output logic                          push_valid_o,
  output gifm_pkg::work_t               push_data_o,
  input  logic                          push_ready_i
);
  import gifm_pkg::*;

  localparam int unsigned AW = (MAX_PARAMS > 1) ? $clog2(MAX_PARAMS) : 1;
  localparam int unsigned MW = $clog2(MAX_PARAMS + 1);
  localparam int unsigned CW = (MW > COUNT_W) ? MW : COUNT_W;
  localparam int unsigned MAX_COUNT = MAX_PARAMS;

  logic [AW-1:0] pos_q, pos_d, pos_cur;
  logic [CW-1:0] pc_ext, n_eff, pos_ext, pos_next;
  logic          last, accept;

  // effective vector length: zero acts as one, clamp at the store depth
  always_comb begin
    pc_ext = CW'(param_count_i);
    if (pc_ext == '0) begin
      n_eff = CW'(1);
    end else if (pc_ext > CW'(MAX_COUNT)) begin
      n_eff = CW'(MAX_COUNT);
    end else begin
      n_eff = pc_ext;
    end
  end

  // position past a shrunk count becomes the final element
  always_comb begin
    pos_ext  = CW'(pos_q);
    pos_cur  = (pos_ext >= n_eff) ? AW'(n_eff - 1'b1) : pos_q;
    pos_next = CW'(pos_cur) + CW'(1);
    last     = (pos_next >= n_eff);
    pos_d    = last ? '0 : AW'(pos_next);
  end

  assign in_i.ready   = push_ready_i & ~clearing_i;
  assign push_valid_o = in_i.valid & ~clearing_i;
  assign accept       = in_i.valid & in_i.ready;

  always_comb begin
    push_data_o.op   = in_i.opcode;
    push_data_o.grad = in_i.gradient_invalid ? '0 : in_i.gradient;
    push_data_o.idx  = IDX_W'(pos_cur);
    push_data_o.last = last;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q <= '0;
    end else if (accept) begin
      pos_q <= pos_d;
    end
  end

endmodule

@@ sv/gifm_back.sv @@
`timescale 1ns / 1ps
// gifm_back: importance store, update arithmetic, tallies and result register
// depends on gifm_pkg, gifm_if, gifm_ram

module gifm_back #(
  parameter int unsigned MAX_PARAMS = gifm_pkg::MAX_PARAMS_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          pop_valid_i,
  input  gifm_pkg::work_t               pop_data_i,
  output logic                          pop_ready_o,
  input  logic [gifm_pkg::IMP_W-1:0]    threshold_i,
  input  logic [gifm_pkg::DECAY_W-1:0]  decay_i,
  output logic                          clearing_o,
  gifm_out_if.source                    out_o
);
  import gifm_pkg::*;

  localparam int unsigned AW = (MAX_PARAMS > 1) ? $clog2(MAX_PARAMS) : 1;

  localparam logic [2:0] S_CLEAR = 3'd0;
  localparam logic [2:0] S_IDLE  = 3'd1;
  localparam logic [2:0] S_LOAD  = 3'd2;
  localparam logic [2:0] S_SCALE = 3'd3;
  localparam logic [2:0] S_SUM   = 3'd4;
  localparam logic [2:0] S_EMIT  = 3'd5;

  logic [2:0]         state_q, state_d;
  logic [AW-1:0]      clr_q, clr_d;
  logic               out_valid_q, out_valid_d;
  logic [COUNT_W-1:0] ft_q, ft_d, nft_q, nft_d, mt_q, mt_d;
  logic [TOTAL_W-1:0] total_q, total_d;

  work_t              work_q;
  logic [IMP_W-1:0]   old_q, nw_q;
  logic [47:0]        sq_prod_q;
  logic [48:0]        p_old_q;
  logic [47:0]        p_sq_q;
  result_t            res_q;

  logic               ram_we;
  logic [AW-1:0]      ram_waddr;
  logic [IMP_W-1:0]   ram_wdata, ram_rdata;

  logic [DECAY_W-1:0] d_eff, one_minus_d;
  logic [GRAD_W-1:0]  g_u, mag;
  logic [47:0]        sq_prod_d, sq_rnd;
  logic [30:0]        sq;
  logic [48:0]        p_old_d;
  logic [47:0]        p_sq_d;
  logic [49:0]        acc;
  logic [IMP_W-1:0]   nw_d;
  logic               grad_op, freeze_before, freeze_now, newly, masked, out_free;
  logic [COUNT_W-1:0] ft_new, nft_new, mt_new;
  logic [TOTAL_W-1:0] total_new;

  gifm_ram #(
    .WIDTH (IMP_W),
    .DEPTH (MAX_PARAMS)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (pop_data_i.idx[AW-1:0]),
    .rdata_o (ram_rdata)
  );

  // arithmetic, one multiply level per state
  assign d_eff       = (decay_i > ONE_Q16) ? ONE_Q16 : decay_i;
  assign one_minus_d = ONE_Q16 - d_eff;
  assign g_u         = work_q.grad;
  assign mag         = g_u[GRAD_W-1] ? GRAD_W'(~g_u + 1'b1) : g_u;
  assign sq_prod_d   = 48'(mag) * 48'(mag);
  assign sq_rnd      = sq_prod_q + 48'd32768;
  assign sq          = sq_rnd[46:16];
  assign grad_op     = (work_q.op == OP_GRADIENT);
  assign p_old_d     = 49'(d_eff) * 49'(old_q);
  assign p_sq_d      = grad_op ? (48'(one_minus_d) * 48'(sq)) : '0;
  assign acc         = 50'(p_old_q) + 50'(p_sq_q) + 50'd32768;
  assign nw_d        = (acc[49:48] != 2'b00) ? '1 : acc[47:16];

  // freeze decisions and tallies
  assign freeze_before = (old_q > threshold_i);
  assign freeze_now    = (nw_q > threshold_i);
  assign newly         = grad_op & ~freeze_before & freeze_now;
  assign masked        = grad_op & freeze_now;
  assign ft_new        = ft_q + COUNT_W'(freeze_now);
  assign nft_new       = nft_q + COUNT_W'(newly);
  assign mt_new        = mt_q + COUNT_W'(masked);
  assign total_new     = total_q + TOTAL_W'(masked);
  assign out_free      = ~out_valid_q | out_o.ready;

  assign pop_ready_o = (state_q == S_IDLE);
  assign clearing_o  = (state_q == S_CLEAR);

  always_comb begin
    state_d     = state_q;
    clr_d       = clr_q;
    out_valid_d = out_valid_q & ~out_o.ready;
    ft_d        = ft_q;
    nft_d       = nft_q;
    mt_d        = mt_q;
    total_d     = total_q;
    ram_we      = 1'b0;
    ram_waddr   = work_q.idx[AW-1:0];
    ram_wdata   = nw_q;
    unique case (state_q)
      S_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_q;
        ram_wdata = '0;
        clr_d     = AW'(clr_q + 1'b1);
        if (clr_q == AW'(MAX_PARAMS - 1)) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (pop_valid_i) begin
          state_d = S_LOAD;
        end
      end
      S_LOAD:  state_d = S_SCALE;
      S_SCALE: state_d = S_SUM;
      S_SUM:   state_d = S_EMIT;
      S_EMIT: begin
        if (out_free) begin
          ram_we      = 1'b1;
          out_valid_d = 1'b1;
          total_d     = total_new;
          ft_d        = work_q.last ? '0 : ft_new;
          nft_d       = work_q.last ? '0 : nft_new;
          mt_d        = work_q.last ? '0 : mt_new;
          state_d     = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      clr_q       <= '0;
      out_valid_q <= 1'b0;
      ft_q        <= '0;
      nft_q       <= '0;
      mt_q        <= '0;
      total_q     <= '0;
    end else begin
      state_q     <= state_d;
      clr_q       <= clr_d;
      out_valid_q <= out_valid_d;
      ft_q        <= ft_d;
      nft_q       <= nft_d;
      mt_q        <= mt_d;
      total_q     <= total_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == S_IDLE && pop_valid_i) begin
      work_q <= pop_data_i;
    end
    if (state_q == S_LOAD) begin
      old_q     <= ram_rdata;
      sq_prod_q <= sq_prod_d;
    end
    if (state_q == S_SCALE) begin
      p_old_q <= p_old_d;
      p_sq_q  <= p_sq_d;
    end
    if (state_q == S_SUM) begin
      nw_q <= nw_d;
    end
    if (state_q == S_EMIT && out_free) begin
      res_q.masked_gradient      <= (grad_op && !freeze_now) ? work_q.grad : '0;
      res_q.frozen               <= freeze_now;
      res_q.first_freeze         <= newly;
      res_q.last                 <= work_q.last;
      res_q.freeze_count         <= work_q.last ? ft_new : '0;
      res_q.newly_frozen_count   <= work_q.last ? nft_new : '0;
      res_q.masked_count         <= work_q.last ? mt_new : '0;
      res_q.masked_running_total <= total_new;
    end
  end

  assign out_o.valid                = out_valid_q;
  assign out_o.masked_gradient      = res_q.masked_gradient;
  assign out_o.frozen               = res_q.frozen;
  assign out_o.first_freeze         = res_q.first_freeze;
  assign out_o.last                 = res_q.last;
  assign out_o.freeze_count         = res_q.freeze_count;
  assign out_o.newly_frozen_count   = res_q.newly_frozen_count;
  assign out_o.masked_count         = res_q.masked_count;
  assign out_o.masked_running_total = res_q.masked_running_total;

endmodule

@@ sv/gradient_importance_freeze_mask_top.sv @@
`timescale 1ns / 1ps
// gradient_importance_freeze_mask_top: apb registers plus front, queue and back
// depends on gifm_pkg, gifm_if, gifm_ram, gifm_queue, gifm_front, gifm_back
//
// usage
// - in_i carries one gradient element per transfer, in parameter order:
//   opcode (gradient or decay tick), signed q8.16 gradient, invalid flag
// - out_o returns exactly one result per input transfer, in order: masked
//   gradient, frozen flags, and on the last element the per-vector counts
// - apb port sets threshold (q16.16), decay (q1.16) and vector length;
//   write only while no item is in flight
// - path: accepted items pass the queue, then the back end, which takes one
//   item at a time and accepts the next only after its sequence of store
//   read, square, scaling multiplies, sum/saturate and store write through
//   the importance ram, then the result register
// - the front takes up to two items ahead into the queue, so the input
//   side keeps moving while a result waits in the output register
// - reset: after rst_ni rises, a clearing pass zeroes all MAX_PARAMS entries
//   of the importance ram, with in_i.ready low; apb writes still work
// - receiver stall: the result register holds, the back end waits before
//   its store write, the queue fills, then in_i.ready drops

module gradient_importance_freeze_mask_top #(
  parameter int unsigned MAX_PARAMS = gifm_pkg::MAX_PARAMS_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  gifm_in_if.sink                       in_i,
  gifm_out_if.source                    out_o,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [gifm_pkg::PADDR_W-1:0]  paddr,
  input  logic [31:0]                   pwdata,
  output logic [31:0]                   prdata,
  output logic                          pready
);
  import gifm_pkg::*;

  logic [IMP_W-1:0]   thr_q;
  logic [DECAY_W-1:0] decay_q;
  logic [COUNT_W-1:0] pcount_q;
  logic               cfg_write;
  logic [1:0]         reg_idx;

  work_t              push_data, pop_data;
  logic               push_valid, push_ready, pop_valid, pop_ready;
  logic               clearing;

  // apb: zero wait states, register index from the word address
  assign pready    = 1'b1;
  assign reg_idx   = paddr[3:2];
  assign cfg_write = psel & penable & pwrite & pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q    <= THRESHOLD_RST;
      decay_q  <= DECAY_RST;
      pcount_q <= PCOUNT_RST;
    end else if (cfg_write) begin
      unique case (reg_idx)
        REG_THRESHOLD: thr_q    <= pwdata;
        REG_DECAY:     decay_q  <= pwdata[DECAY_W-1:0];
        REG_PCOUNT:    pcount_q <= pwdata[COUNT_W-1:0];
        default:       ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_THRESHOLD: prdata = thr_q;
      REG_DECAY:     prdata = 32'(decay_q);
      REG_PCOUNT:    prdata = 32'(pcount_q);
      default:       prdata = '0;
    endcase
  end

  // front: position tracking and classification
  gifm_front #(
    .MAX_PARAMS (MAX_PARAMS)
  ) u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_i          (in_i),
    .param_count_i (pcount_q),
    .clearing_i    (clearing),
    .push_valid_o  (push_valid),
    .push_data_o   (push_data),
    .push_ready_i  (push_ready)
  );

  // decoupling queue between the two halves
  gifm_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (push_valid),
    .push_data_i  (push_data),
    .push_ready_o (push_ready),
    .pop_valid_o  (pop_valid),
    .pop_data_o   (pop_data),
    .pop_ready_i  (pop_ready)
  );

  // back: store update, masking, tallies, result register
  gifm_back #(
    .MAX_PARAMS (MAX_PARAMS)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .pop_valid_i (pop_valid),
    .pop_data_i  (pop_data),
    .pop_ready_o (pop_ready),
    .threshold_i (thr_q),
    .decay_i     (decay_q),
    .clearing_o  (clearing),
    .out_o       (out_o)
  );

endmodule
